// File: hw/rtl/hsv_to_rgb_led_frame_assert.svh
// assertion macros for the hsv to rgb led frame converter
`ifndef HSV_TO_RGB_LED_FRAME_ASSERT_SVH
`define HSV_TO_RGB_LED_FRAME_ASSERT_SVH

`ifndef SYNTH
// condition must hold in the same cycle
`define HSVLED_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hsvled check failed: same cycle");
// condition must hold in the following cycle
`define HSVLED_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hsvled check failed: next cycle");
`else
`define HSVLED_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define HSVLED_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// File: hw/rtl/hsvled_pkg.sv
// shared types, constants and helpers for the hsv to rgb led frame converter
`timescale 1ns / 1ps
`default_nettype none

package hsvled_pkg;

   // 255 * 65536, full scale of the q and t numerators
   localparam logic [23:0] SCALE_K = 24'hFF0000;
   // one full turn of the hue fraction
   localparam logic [16:0] HUE_ONE = 17'h10000;
   // reciprocal of 255 for 16-bit dividends, used with a shift of 23
   localparam logic [31:0] RECIP_255 = 32'h0000_8081;

   localparam logic FMT_GLOBAL_BYTE = 1'b0;
   localparam logic FMT_HIGH_BITS   = 1'b1;

   // per-stage advance enables
   typedef struct packed {
      logic st1;
      logic st2;
      logic st3;
      logic st4;
      logic st5;
   } adv_type;

   // after the hue stage
   typedef struct packed {
      logic [2:0]  sext;
      logic [15:0] frac;
      logic [7:0]  sat;
      logic [7:0]  val;
   } hue_stage_type;

   // after the product stages
   typedef struct packed {
      logic [2:0] sext;
      logic [7:0] sat;
      logic [7:0] val;
      logic [7:0] p;
      logic [7:0] q;
      logic [7:0] t;
   } chan_stage_type;

   // exact floor(x / 255) for 16-bit x up to 65279, where the quotient fits in eight bits
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [31:0] prod;
      prod = {16'b0, x} * RECIP_255;
      return prod[30:23];
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/hsv_to_rgb_led_frame.sv
// top level of the hsv to rgb led frame converter
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+----------------------------------
//   req     | in        | req_valid/req_stall| hue, saturation, brightness
//   rsp     | out       | rsp_valid/rsp_stall| red, green, blue, led_frame
//   csr     | in        | csr_wr_en          | frame_format (csr_wr_data)
//
// one pixel per clock sustained while rsp_stall stays low; results are shown from the select/pack register
// five register stages: hue*6, products, full-scale multiply, divide by 255, select/pack
// each stage moves up when its slot is empty or the next one moves, so bubbles close up
// under a response stall; req_stall rises only once all five stages hold a pixel
// synchronous reset empties the pipe and sets the frame format to the global byte layout
`timescale 1ns / 1ps
`default_nettype none
`include "hsv_to_rgb_led_frame_assert.svh"

module hsv_to_rgb_led_frame (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [15:0] req_hue,
   input  wire logic [7:0]  req_saturation,
   input  wire logic [7:0]  req_brightness,
   // response channel
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [7:0]  rsp_red,
   output      logic [7:0]  rsp_green,
   output      logic [7:0]  rsp_blue,
   output      logic [31:0] rsp_led_frame,
   // configuration
   input  wire logic        csr_wr_en,
   input  wire logic        csr_wr_data
);
   import hsvled_pkg::*;

   localparam int unsigned NUM_STAGES = 5;

   adv_type                 adv;
   logic [NUM_STAGES-1:0]   adv_vec;
   logic [NUM_STAGES-1:0]   valid_ff;
   logic [NUM_STAGES-1:0]   valid_in;
   logic                    fmt_ff;
   hue_stage_type           hue_stage;
   chan_stage_type          chan_stage;

   // frame format register; the user must write it only while the pipe is empty, the block does not enforce it
   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff <= FMT_GLOBAL_BYTE;
      end else if (csr_wr_en) begin
         fmt_ff <= csr_wr_data;
      end
   end

   // advance chain from the output back to the input; bit 0 is stage one
   always_comb begin
      adv.st5 = !valid_ff[4] || !rsp_stall;
      adv.st4 = !valid_ff[3] || adv.st5;
      adv.st3 = !valid_ff[2] || adv.st4;
      adv.st2 = !valid_ff[1] || adv.st3;
      adv.st1 = !valid_ff[0] || adv.st2;
      adv_vec = {adv.st5, adv.st4, adv.st3, adv.st2, adv.st1};
      valid_in = {valid_ff[NUM_STAGES-2:0], req_valid};
   end

   // valid bits follow the data; a stage that holds keeps its bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= (valid_ff & ~adv_vec) | (valid_in & adv_vec);
      end
   end

   assign req_stall = !adv.st1;
   assign rsp_valid = valid_ff[NUM_STAGES-1];

   hsvled_hue u_hue (
      .clock      (clock),
      .adv        (adv),
      .hue        (req_hue),
      .saturation (req_saturation),
      .brightness (req_brightness),
      .stage_out  (hue_stage)
   );

   hsvled_prod u_prod (
      .clock     (clock),
      .adv       (adv),
      .stage_in  (hue_stage),
      .stage_out (chan_stage)
   );

   hsvled_pack u_pack (
      .clock        (clock),
      .adv          (adv),
      .stage_in     (chan_stage),
      .frame_format (fmt_ff),
      .red          (rsp_red),
      .green        (rsp_green),
      .blue         (rsp_blue),
      .led_frame    (rsp_led_frame)
   );

   // input is held back only when every stage is occupied
   `HSVLED_ASSERT_NOW(a_stall_only_when_full, clock, reset, req_stall, (&valid_ff))
   // a request transfer always lands in stage one
   `HSVLED_ASSERT_NEXT(a_req_lands, clock, reset, (req_valid && !req_stall), valid_ff[0])
   // a held middle stage keeps its pixel
   `HSVLED_ASSERT_NEXT(a_mid_hold, clock, reset, (valid_ff[2] && !adv.st4), valid_ff[2])
   // global byte layout carries red in the low byte
   `HSVLED_ASSERT_NOW(a_fmt_global, clock, reset, (rsp_valid && fmt_ff == FMT_GLOBAL_BYTE), (rsp_led_frame[31:24] == 8'hFF && rsp_led_frame[7:0] == rsp_red))

endmodule

`default_nettype wire

// File: hw/rtl/hsvled_hue.sv
// first stage: hue times six split into sextant and fraction
`timescale 1ns / 1ps
`default_nettype none

module hsvled_hue (
   input  wire logic                       clock,
   input  wire hsvled_pkg::adv_type        adv,
   input  wire logic [15:0]                hue,
   input  wire logic [7:0]                 saturation,
   input  wire logic [7:0]                 brightness,
   output      hsvled_pkg::hue_stage_type  stage_out
);
   import hsvled_pkg::*;

   hue_stage_type stage_ff;
   hue_stage_type stage_in;
   logic [18:0]   hue6;

   // hue * 6 as 4h + 2h
   always_comb begin
      hue6           = {1'b0, hue, 2'b00} + {2'b00, hue, 1'b0};
      stage_in.sext  = hue6[18:16];
      stage_in.frac  = hue6[15:0];
      stage_in.sat   = saturation;
      stage_in.val   = brightness;
   end

   always_ff @(posedge clock) begin
      if (adv.st1) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_out = stage_ff;

endmodule

`default_nettype wire

// File: hw/rtl/hsvled_prod.sv
// stages two to four: products, full-scale subtraction and divide by 255
`timescale 1ns / 1ps
`default_nettype none

module hsvled_prod (
   input  wire logic                        clock,
   input  wire hsvled_pkg::adv_type         adv,
   input  wire hsvled_pkg::hue_stage_type   stage_in,
   output      hsvled_pkg::chan_stage_type  stage_out
);
   import hsvled_pkg::*;

   // stage two
   logic [2:0]  sext2_ff;
   logic [7:0]  sat2_ff;
   logic [7:0]  val2_ff;
   logic [23:0] sf_ff;
   logic [24:0] sg_ff;
   logic [15:0] pv_ff;
   logic [23:0] sf_in;
   logic [24:0] sg_in;
   logic [15:0] pv_in;
   logic [16:0] frac_rem;

   // stage three
   logic [2:0]  sext3_ff;
   logic [7:0]  sat3_ff;
   logic [7:0]  val3_ff;
   logic [15:0] qy_ff;
   logic [15:0] ty_ff;
   logic [7:0]  p3_ff;
   logic [23:0] qa;
   logic [24:0] ta_wide;
   logic [31:0] qprod;
   logic [31:0] tprod;

   // stage four
   chan_stage_type stage4_ff;
   chan_stage_type stage4_in;

   always_comb begin
      frac_rem = HUE_ONE - {1'b0, stage_in.frac};
      sf_in    = {16'b0, stage_in.sat} * {8'b0, stage_in.frac};
      sg_in    = {17'b0, stage_in.sat} * {8'b0, frac_rem};
      pv_in    = {8'b0, stage_in.val} * {8'b0, ~stage_in.sat};
   end

   always_ff @(posedge clock) begin
      if (adv.st2) begin
         sext2_ff <= stage_in.sext;
         sat2_ff  <= stage_in.sat;
         val2_ff  <= stage_in.val;
         sf_ff    <= sf_in;
         sg_ff    <= sg_in;
         pv_ff    <= pv_in;
      end
   end

   // both differences stay within 0..SCALE_K
   always_comb begin
      qa      = SCALE_K - sf_ff;
      ta_wide = {1'b0, SCALE_K} - sg_ff;
      qprod   = {24'b0, val2_ff} * {8'b0, qa};
      tprod   = {24'b0, val2_ff} * {8'b0, ta_wide[23:0]};
   end

   always_ff @(posedge clock) begin
      if (adv.st3) begin
         sext3_ff <= sext2_ff;
         sat3_ff  <= sat2_ff;
         val3_ff  <= val2_ff;
         qy_ff    <= qprod[31:16];
         ty_ff    <= tprod[31:16];
         p3_ff    <= div255(pv_ff);
      end
   end

   always_comb begin
      stage4_in.sext = sext3_ff;
      stage4_in.sat  = sat3_ff;
      stage4_in.val  = val3_ff;
      stage4_in.p    = p3_ff;
      stage4_in.q    = div255(qy_ff);
      stage4_in.t    = div255(ty_ff);
   end

   always_ff @(posedge clock) begin
      if (adv.st4) begin
         stage4_ff <= stage4_in;
      end
   end

   assign stage_out = stage4_ff;

endmodule

`default_nettype wire

// File: hw/rtl/hsvled_pack.sv
// last stage: sextant channel select, grey override and led word packing
`timescale 1ns / 1ps
`default_nettype none

module hsvled_pack (
   input  wire logic                        clock,
   input  wire hsvled_pkg::adv_type         adv,
   input  wire hsvled_pkg::chan_stage_type  stage_in,
   input  wire logic                        frame_format,
   output      logic [7:0]                  red,
   output      logic [7:0]                  green,
   output      logic [7:0]                  blue,
   output      logic [31:0]                 led_frame
);
   import hsvled_pkg::*;

   localparam logic [2:0] SEXT_RED_YELLOW    = 3'd0;
   localparam logic [2:0] SEXT_YELLOW_GREEN  = 3'd1;
   localparam logic [2:0] SEXT_GREEN_CYAN    = 3'd2;
   localparam logic [2:0] SEXT_CYAN_BLUE     = 3'd3;
   localparam logic [2:0] SEXT_BLUE_MAGENTA  = 3'd4;

   logic [7:0]  red_ff, green_ff, blue_ff;
   logic [31:0] frame_ff;
   logic [7:0]  red_in, green_in, blue_in;
   logic [31:0] frame_in;

   always_comb begin
      unique case (stage_in.sext)
         SEXT_RED_YELLOW: begin
            red_in = stage_in.val; green_in = stage_in.t;   blue_in = stage_in.p;
         end
         SEXT_YELLOW_GREEN: begin
            red_in = stage_in.q;   green_in = stage_in.val; blue_in = stage_in.p;
         end
         SEXT_GREEN_CYAN: begin
            red_in = stage_in.p;   green_in = stage_in.val; blue_in = stage_in.t;
         end
         SEXT_CYAN_BLUE: begin
            red_in = stage_in.p;   green_in = stage_in.q;   blue_in = stage_in.val;
         end
         SEXT_BLUE_MAGENTA: begin
            red_in = stage_in.t;   green_in = stage_in.p;   blue_in = stage_in.val;
         end
         default: begin
            red_in = stage_in.val; green_in = stage_in.p;   blue_in = stage_in.q;
         end
      endcase

      // zero saturation is a grey at the given value
      if (stage_in.sat == 8'd0) begin
         red_in   = stage_in.val;
         green_in = stage_in.val;
         blue_in  = stage_in.val;
      end

      unique case (frame_format)
         FMT_HIGH_BITS:   frame_in = {blue_in | 8'h80, red_in | 8'h80, green_in | 8'h80, 8'h00};
         FMT_GLOBAL_BYTE: frame_in = {8'hFF, blue_in, green_in, red_in};
         default:         frame_in = {8'hFF, blue_in, green_in, red_in};
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv.st5) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
         frame_ff <= frame_in;
      end
   end

   assign red       = red_ff;
   assign green     = green_ff;
   assign blue      = blue_ff;
   assign led_frame = frame_ff;

endmodule

`default_nettype wire

// File: sim/hsv_pixel_checker.sv
// checker for the hsv to rgb led frame converter: predicts each pixel and compares results
`timescale 1ns / 1ps

module hsv_pixel_checker
   import hsvled_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [15:0] req_hue,
   input  logic [7:0]  req_saturation,
   input  logic [7:0]  req_brightness,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [7:0]  rsp_red,
   input  logic [7:0]  rsp_green,
   input  logic [7:0]  rsp_blue,
   input  logic [31:0] rsp_led_frame,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   output int          fail_count,
   output int          pending_count
);

   localparam longint unsigned FULL_SCALE = 64'd16711680;

   typedef struct packed {
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [31:0] frame;
   } rgb_frame_type;

   rgb_frame_type expected_pixels[$];
   rgb_frame_type want;
   logic          led_format;

   function automatic rgb_frame_type hsv_to_expected(input logic [15:0] hue,
         input logic [7:0] sat, input logic [7:0] val, input logic fmt);
      logic [18:0]     hue6;
      longint unsigned frac, s, v, p, q, t;
      logic [7:0]      r, g, b;
      rgb_frame_type   px;
      hue6 = 19'(hue) * 19'd6;
      frac = hue6[15:0];
      s = sat;
      v = val;
      p = (v * (255 - s)) / 255;
      q = (v * (FULL_SCALE - s * frac)) / FULL_SCALE;
      t = (v * (FULL_SCALE - s * (65536 - frac))) / FULL_SCALE;
      // sextant picks which channel is the value and which are p, q, t
      case (hue6[18:16])
         3'd0: begin r = 8'(v); g = 8'(t); b = 8'(p); end
         3'd1: begin r = 8'(q); g = 8'(v); b = 8'(p); end
         3'd2: begin r = 8'(p); g = 8'(v); b = 8'(t); end
         3'd3: begin r = 8'(p); g = 8'(q); b = 8'(v); end
         3'd4: begin r = 8'(t); g = 8'(p); b = 8'(v); end
         default: begin r = 8'(v); g = 8'(p); b = 8'(q); end
      endcase
      // no saturation means grey at the given value
      if (sat == 8'd0) begin
         r = val;
         g = val;
         b = val;
      end
      px.red = r;
      px.green = g;
      px.blue = b;
      if (fmt == FMT_HIGH_BITS)
         px.frame = {b | 8'h80, r | 8'h80, g | 8'h80, 8'h00};
      else
         px.frame = {8'hFF, b, g, r};
      return px;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0d ns: mismatch: %s", $time, msg);
      fail_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_pixels.delete();
         led_format = FMT_GLOBAL_BYTE;
         fail_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               report_mismatch("result transfer with no pixel outstanding");
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_red !== want.red)
                  report_mismatch($sformatf("red got %0d want %0d", rsp_red, want.red));
               if (rsp_green !== want.green)
                  report_mismatch($sformatf("green got %0d want %0d", rsp_green, want.green));
               if (rsp_blue !== want.blue)
                  report_mismatch($sformatf("blue got %0d want %0d", rsp_blue, want.blue));
               if (rsp_led_frame !== want.frame)
                  report_mismatch($sformatf("led frame got %08h want %08h",
                                            rsp_led_frame, want.frame));
            end
         end
         if (req_valid && !req_stall)
            expected_pixels.push_back(hsv_to_expected(req_hue, req_saturation,
                                                      req_brightness, led_format));
         if (csr_wr_en)
            led_format = csr_wr_data;
      end
      pending_count = expected_pixels.size();
   end

endmodule

// File: sim/tb.sv
// testbench top for the hsv to rgb led frame converter: stimulus, idling and verdict
`timescale 1ns / 1ps

module tb;
   import hsvled_pkg::*;

   // cycles with no transfer on either channel before the run is abandoned
   localparam int QUIET_LIMIT = 1000;
   // items per random phase, eight phases in all
   localparam int PHASE_ITEMS = 250;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [15:0] req_hue;
   logic [7:0]  req_saturation;
   logic [7:0]  req_brightness;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_red;
   logic [7:0]  rsp_green;
   logic [7:0]  rsp_blue;
   logic [31:0] rsp_led_frame;
   logic        csr_wr_en;
   logic        csr_wr_data;

   int fail_count;
   int pending_count;
   int quiet_cycles;
   // chance in a hundred that the sender idles or the receiver stalls in a cycle
   int gap_pct;
   int stall_pct;

   hsv_to_rgb_led_frame DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_hue        (req_hue),
      .req_saturation (req_saturation),
      .req_brightness (req_brightness),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .rsp_led_frame  (rsp_led_frame),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   // watches both channels and the register port, predicts every pixel
   hsv_pixel_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_hue        (req_hue),
      .req_saturation (req_saturation),
      .req_brightness (req_brightness),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .rsp_led_frame  (rsp_led_frame),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .fail_count     (fail_count),
      .pending_count  (pending_count)
   );

   always #5 clock = ~clock;

   // receiver side: random stall, redrawn every falling edge
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // watchdog: a long stretch with no transfer at all means the block has hung
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // one pixel transfer; called and returning at a falling edge, valid left high
   task automatic send_pixel(input logic [15:0] hue, input logic [7:0] sat,
                             input logic [7:0] val);
      while ($urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_hue        <= hue;
      req_saturation <= sat;
      req_brightness <= val;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // drop valid, let every pixel come back, then allow for the pipe depth
   task automatic drain;
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // register write, only ever issued with the pipe empty
   task automatic write_format(input logic fmt);
      csr_wr_data <= fmt;
      csr_wr_en   <= 1'b1;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin
      logic [15:0] hue;
      logic [7:0]  sat;
      logic [7:0]  val;
      int          k;

      clock          = 1'b0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_hue        = '0;
      req_saturation = '0;
      req_brightness = '0;
      rsp_stall      = 1'b0;
      csr_wr_en      = 1'b0;
      csr_wr_data    = 1'b0;
      gap_pct        = 0;
      stall_pct      = 0;

      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      write_format(FMT_GLOBAL_BYTE);

      // directed: field extremes, greys, and both sides of every sextant boundary
      send_pixel(16'd0,     8'd255, 8'd255);
      send_pixel(16'd65535, 8'd255, 8'd255);
      send_pixel(16'd0,     8'd0,   8'd255);
      send_pixel(16'd12345, 8'd0,   8'd200);
      send_pixel(16'd0,     8'd0,   8'd0);
      send_pixel(16'd65535, 8'd0,   8'd0);
      send_pixel(16'd10922, 8'd255, 8'd255);
      send_pixel(16'd10923, 8'd255, 8'd255);
      send_pixel(16'd21845, 8'd255, 8'd255);
      send_pixel(16'd21846, 8'd255, 8'd255);
      send_pixel(16'd32767, 8'd255, 8'd255);
      send_pixel(16'd32768, 8'd255, 8'd255);
      send_pixel(16'd43690, 8'd255, 8'd255);
      send_pixel(16'd43691, 8'd255, 8'd255);
      send_pixel(16'd54613, 8'd255, 8'd255);
      send_pixel(16'd54614, 8'd255, 8'd255);
      send_pixel(16'd5461,  8'd128, 8'd255);
      send_pixel(16'd60000, 8'd1,   8'd255);
      send_pixel(16'd30000, 8'd255, 8'd1);
      send_pixel(16'd50000, 8'd254, 8'd254);
      drain();

      // random phases: each idling pattern under both frame layouts
      for (int ph = 0; ph < 8; ph++) begin
         write_format((ph % 2 == 0) ? FMT_HIGH_BITS : FMT_GLOBAL_BYTE);
         case (ph / 2)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 47; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 47; end
            default: begin gap_pct = 28; stall_pct = 28; end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // hue mostly uniform, a quarter of the time hugging a sextant edge
            if ($urandom_range(0, 3) == 0) begin
               k   = $urandom_range(0, 5);
               hue = 16'(((k << 16) / 6) + int'($urandom_range(0, 4)) - 2);
            end else begin
               hue = 16'($urandom);
            end
            case ($urandom_range(0, 7))
               0: sat = 8'd0;
               1: sat = 8'd255;
               default: sat = 8'($urandom);
            endcase
            case ($urandom_range(0, 7))
               0: val = 8'd0;
               1: val = 8'd255;
               default: val = 8'($urandom);
            endcase
            send_pixel(hue, sat, val);
         end
         drain();
      end

      gap_pct   = 0;
      stall_pct = 0;
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
